// File: design/lph_pkg.sv
// Shared types and constants of the linear probing hash table.
package lph_pkg;

  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 64;
  localparam int SLOT_W   = 10;
  localparam int SUM_W    = 11;

  localparam logic CMD_INSERT = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_RESERVED  = 2'd3
  } lph_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_EMIT
  } lph_state_t;

  typedef struct packed {
    logic               command;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } lph_in_t;

  typedef struct packed {
    lph_status_t        status;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] found_value;
  } lph_out_t;

endpackage

// File: design/lph_ram.sv
// Generic single write port RAM with one registered read port.
module lph_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered and valid in the next cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/lph_hash.sv
// Four stage home slot unit: byte sum of the key modulo the table depth.
module lph_hash #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [lph_pkg::KEY_W-1:0]      key,
  output logic                           done,
  output logic [$clog2(TABLE_DEPTH)-1:0] home
);
  import lph_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / TABLE_DEPTH);
  localparam logic [16:0] DEPTH_C = 17'(TABLE_DEPTH);

  logic [3:0]       stg_v_r, stg_v_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] sum2_r;
  logic [SUM_W-1:0] q_r, q_nxt;
  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [AW-1:0]    home_r, home_nxt;
  logic [42:0]      prod_q;
  logic [27:0]      prod_d;
  logic [16:0]      rem_ext;

  // Stage one: add the eight key bytes
  always_comb begin
    sum_nxt = '0;
    for (int b = 0; b < 8; b++) begin
      sum_nxt = sum_nxt + SUM_W'(key[8*b +: 8]);
    end
  end

  // Stage two: quotient estimate by reciprocal, low by at most one
  assign prod_q = 43'(sum_r) * 43'(RECIP);
  assign q_nxt  = prod_q[42:32];

  // Stage three: remainder below twice the depth
  assign prod_d  = 28'(q_r) * 28'(DEPTH_C);
  assign rem_nxt = sum2_r - prod_d[SUM_W-1:0];

  // Stage four: final correction
  assign rem_ext  = 17'(rem_r);
  assign home_nxt = (rem_ext >= DEPTH_C) ? AW'(rem_ext - DEPTH_C) : AW'(rem_ext);

  assign stg_v_nxt = {stg_v_r[2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  // Hold payload through the stages
  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    sum2_r <= sum_r;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    home_r <= home_nxt;
  end

  assign done = stg_v_r[3];
  assign home = home_r;

endmodule

// File: design/linear_probe_hash_table_core.sv
// Top level of the linear probing hash table: control sequencer and stores.
//
// Insert or look up 64-bit keys with 64-bit value handles. Input transfers
// on in_valid && !in_stall carry command, key and value; each produces one
// result transfer on out_valid && !out_stall with status, slot and value.
// Key zero is reserved and returns its own status without hashing. Other
// commands compute the home slot in the hash unit (byte sum, then a
// reciprocal modulo over three stages), then probe one slot per cycle,
// 1 to TABLE_DEPTH probes, set by the single read port of the key and value
// RAMs. Only one command is in flight; the next input is taken while a
// result still waits in the output register, and a finished result holds
// in the sequencer while the receiver stalls.
// After reset a clearing pass writes every key slot to empty, one slot a
// cycle; in_stall stays high during the pass.
// The value RAM is not cleared: a value is only read at an occupied slot.
module linear_probe_hash_table_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lph_pkg::lph_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lph_pkg::lph_out_t out_data
);
  import lph_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  lph_state_t         state_r, state_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      n_r, n_nxt;
  logic               cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  lph_out_t           res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  lph_out_t           out_data_r, out_data_nxt;

  logic               in_xfer;
  logic               hash_start;
  logic               hash_done;
  logic [AW-1:0]      hash_home;
  logic [AW-1:0]      idx_inc;
  logic [AW-1:0]      raddr;
  logic               key_we;
  logic [KEY_W-1:0]   key_wdata;
  logic               val_we;
  logic [KEY_W-1:0]   key_rdata;
  logic [VALUE_W-1:0] val_rdata;

  assign in_stall   = (state_r != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign hash_start = in_xfer && (in_data.key != '0);
  assign idx_inc    = (idx_r == LAST_IDX) ? '0 : idx_r + AW'(1);

  lph_hash #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .start(hash_start),
    .key  (in_data.key),
    .done (hash_done),
    .home (hash_home)
  );

  lph_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(idx_r),
    .wdata(key_wdata),
    .raddr(raddr),
    .rdata(key_rdata)
  );

  lph_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_val_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(idx_r),
    .wdata(value_r),
    .raddr(raddr),
    .rdata(val_rdata)
  );

  // Sequencer: clear, hash, probe, emit
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    raddr         = idx_inc;
    key_we        = 1'b0;
    key_wdata     = key_r;
    val_we        = 1'b0;

    // Drop the output once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        key_we    = 1'b1;
        key_wdata = '0;
        idx_nxt   = idx_inc;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.key == '0) begin
            res_nxt   = '{status: STATUS_RESERVED, slot: '0, found_value: '0};
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        raddr = hash_home;
        if (hash_done) begin
          idx_nxt   = hash_home;
          n_nxt     = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        // Read data belongs to idx_r; the next slot is already being read
        if (cmd_r == CMD_INSERT) begin
          priority if (key_rdata == '0) begin
            key_we    = 1'b1;
            val_we    = 1'b1;
            res_nxt   = '{status: STATUS_OK, slot: SLOT_W'(idx_r), found_value: '0};
            state_nxt = S_EMIT;
          end else if (n_r == LAST_IDX) begin
            res_nxt   = '{status: STATUS_FULL, slot: '0, found_value: '0};
            state_nxt = S_EMIT;
          end else begin
            idx_nxt = idx_inc;
            n_nxt   = n_r + AW'(1);
          end
        end else begin
          priority if (key_rdata == key_r) begin
            res_nxt   = '{status: STATUS_OK, slot: SLOT_W'(idx_r),
                          found_value: val_rdata};
            state_nxt = S_EMIT;
          end else if (key_rdata == '0 || n_r == LAST_IDX) begin
            res_nxt   = '{status: STATUS_NOT_FOUND, slot: '0, found_value: '0};
            state_nxt = S_EMIT;
          end else begin
            idx_nxt = idx_inc;
            n_nxt   = n_r + AW'(1);
          end
        end
      end
      S_EMIT: begin
        // Hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= in_data.command;
      key_r   <= in_data.key;
      value_r <= in_data.value;
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
